// ===== src/assert_macros.svh =====
// Assertion macros used by the checker module of the scheduler.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the antecedent implies the consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Checks that the antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== src/tcpqs_pkg.sv =====
// Types and constants shared by the three-class priority queue scheduler.
// Depends on nothing.
`timescale 1ns / 1ps

package tcpqs_pkg;

    localparam int NUM_CLASSES = 3;
    localparam int ID_W        = 37;
    localparam int TOTAL_W     = 16;
    localparam int UPR_W       = 4;

    localparam logic [0:0] REQ_ENQUEUE = 1'b0;
    localparam logic [0:0] REQ_SERVE   = 1'b1;

    localparam logic [1:0] CLASS_EMERGENCY = 2'd0;
    localparam logic [1:0] CLASS_URGENT    = 2'd1;
    localparam logic [1:0] CLASS_REGULAR   = 2'd2;
    localparam logic [1:0] CLASS_INVALID   = 2'd3;

    localparam logic [2:0] STATUS_ENQUEUED = 3'd0;
    localparam logic [2:0] STATUS_SERVED   = 3'd1;
    localparam logic [2:0] STATUS_EMPTY    = 3'd2;
    localparam logic [2:0] STATUS_FULL     = 3'd3;
    localparam logic [2:0] STATUS_INVALID  = 3'd4;

    localparam logic [TOTAL_W-1:0] COUNT_MAX = 16'hFFFF;
    localparam logic [UPR_W-1:0]   UPR_RESET = 4'd3;

    typedef struct packed {
        logic [0:0]      req_type;
        logic [1:0]      client_class;
        logic [ID_W-1:0] client_id;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [1:0]         served_class;
        logic [ID_W-1:0]    served_id;
        logic [TOTAL_W-1:0] served_emergency;
        logic [TOTAL_W-1:0] served_urgent;
        logic [TOTAL_W-1:0] served_regular;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic execute;
        logic load;
    } cmd_t;

endpackage

// ===== src/tcpqs_ctrl.sv =====
// Controller state machine of the scheduler: handshakes and datapath commands.
// Depends on tcpqs_pkg.
`timescale 1ns / 1ps

module tcpqs_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output tcpqs_pkg::cmd_t    cmd
);

    tcpqs_pkg::state_t state_reg;
    tcpqs_pkg::state_t state_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tcpqs_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tcpqs_pkg::ST_EXEC;
                end
            end
            tcpqs_pkg::ST_EXEC:
            begin
                state_next = tcpqs_pkg::ST_DONE;
            end
            tcpqs_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = in_valid ? tcpqs_pkg::ST_EXEC : tcpqs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tcpqs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = (state_reg == tcpqs_pkg::ST_IDLE)
                   || ((state_reg == tcpqs_pkg::ST_DONE) && out_free);
        cmd.capture = in_valid && in_ready;
        cmd.execute = (state_reg == tcpqs_pkg::ST_EXEC);
        cmd.load    = (state_reg == tcpqs_pkg::ST_DONE) && out_free;
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcpqs_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== src/tcpqs_dp.sv =====
// Datapath of the scheduler: client store, queue pointers, counters and result register.
// Depends on tcpqs_pkg; driven by commands from tcpqs_ctrl.
`timescale 1ns / 1ps

module tcpqs_dp #(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  tcpqs_pkg::cmd_t                 cmd,
    input  tcpqs_pkg::in_item_t             in_item,
    input  logic                            cfg_wr_en,
    input  logic [tcpqs_pkg::UPR_W-1:0]     cfg_wr_data,
    output tcpqs_pkg::out_item_t            out_item
);

    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_D   = tcpqs_pkg::NUM_CLASSES * QUEUE_DEPTH;
    localparam int ADDR_W  = $clog2(MEM_D);
    localparam int NC      = tcpqs_pkg::NUM_CLASSES;
    localparam int TW      = tcpqs_pkg::TOTAL_W;

    logic [tcpqs_pkg::ID_W-1:0] mem [MEM_D];

    tcpqs_pkg::in_item_t        in_reg;
    tcpqs_pkg::out_item_t       out_item_reg;
    logic [PTR_W-1:0]           rd_ptr_reg [NC];
    logic [PTR_W-1:0]           rd_ptr_next [NC];
    logic [PTR_W-1:0]           wr_ptr_reg [NC];
    logic [PTR_W-1:0]           wr_ptr_next [NC];
    logic [CNT_W-1:0]           count_reg [NC];
    logic [CNT_W-1:0]           count_next [NC];
    logic [TW-1:0]              total_reg [NC];
    logic [TW-1:0]              total_next [NC];
    logic [tcpqs_pkg::UPR_W-1:0] streak_reg;
    logic [tcpqs_pkg::UPR_W-1:0] streak_next;
    logic [tcpqs_pkg::UPR_W-1:0] upr_reg;
    logic [2:0]                 res_status_reg;
    logic [2:0]                 res_status_next;
    logic [1:0]                 res_class_reg;
    logic [1:0]                 res_class_next;
    logic                       res_served_reg;
    logic                       res_served_next;
    logic [tcpqs_pkg::ID_W-1:0] rd_data_reg;
    logic                       wr_en;
    logic                       rd_en;
    logic [ADDR_W-1:0]          wr_addr;
    logic [ADDR_W-1:0]          rd_addr;
    logic [1:0]                 cls;
    logic [1:0]                 pick;
    logic                       all_empty;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] mem_addr(input logic [1:0] c,
                                                   input logic [PTR_W-1:0] p);
        return ADDR_W'(c) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p);
    endfunction

    assign cls       = in_reg.client_class;
    assign all_empty = (count_reg[tcpqs_pkg::CLASS_EMERGENCY] == '0)
                    && (count_reg[tcpqs_pkg::CLASS_URGENT] == '0)
                    && (count_reg[tcpqs_pkg::CLASS_REGULAR] == '0);
    assign out_item  = out_item_reg;

    always_comb
    begin
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        streak_next     = streak_reg;
        res_status_next = res_status_reg;
        res_class_next  = res_class_reg;
        res_served_next = res_served_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        wr_addr         = '0;
        rd_addr         = '0;
        pick            = tcpqs_pkg::CLASS_EMERGENCY;
        if (cmd.execute)
        begin
            res_class_next  = tcpqs_pkg::CLASS_EMERGENCY;
            res_served_next = 1'b0;
            if (in_reg.req_type == tcpqs_pkg::REQ_ENQUEUE)
            begin
                priority if (cls == tcpqs_pkg::CLASS_INVALID)
                begin
                    res_status_next = tcpqs_pkg::STATUS_INVALID;
                end
                else if (count_reg[cls] == CNT_W'(QUEUE_DEPTH))
                begin
                    res_status_next = tcpqs_pkg::STATUS_FULL;
                end
                else
                begin
                    wr_en            = 1'b1;
                    wr_addr          = mem_addr(cls, wr_ptr_reg[cls]);
                    wr_ptr_next[cls] = ptr_inc(wr_ptr_reg[cls]);
                    count_next[cls]  = count_reg[cls] + CNT_W'(1);
                    res_status_next  = tcpqs_pkg::STATUS_ENQUEUED;
                end
            end
            else if (all_empty)
            begin
                res_status_next = tcpqs_pkg::STATUS_EMPTY;
            end
            else
            begin
                priority if (count_reg[tcpqs_pkg::CLASS_EMERGENCY] != '0)
                begin
                    pick = tcpqs_pkg::CLASS_EMERGENCY;
                end
                else if (count_reg[tcpqs_pkg::CLASS_URGENT] != '0)
                begin
                    priority if (streak_reg < upr_reg)
                    begin
                        pick        = tcpqs_pkg::CLASS_URGENT;
                        streak_next = streak_reg + 4'd1;
                    end
                    else if (count_reg[tcpqs_pkg::CLASS_REGULAR] != '0)
                    begin
                        pick        = tcpqs_pkg::CLASS_REGULAR;
                        streak_next = '0;
                    end
                    else
                    begin
                        pick = tcpqs_pkg::CLASS_URGENT;
                    end
                end
                else
                begin
                    pick        = tcpqs_pkg::CLASS_REGULAR;
                    streak_next = '0;
                end
                res_status_next   = tcpqs_pkg::STATUS_SERVED;
                res_class_next    = pick;
                res_served_next   = 1'b1;
                rd_en             = 1'b1;
                rd_addr           = mem_addr(pick, rd_ptr_reg[pick]);
                rd_ptr_next[pick] = ptr_inc(rd_ptr_reg[pick]);
                count_next[pick]  = count_reg[pick] - CNT_W'(1);
                if (total_reg[pick] != tcpqs_pkg::COUNT_MAX)
                begin
                    total_next[pick] = total_reg[pick] + TW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= in_reg.client_id;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_reg <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NC; i++)
            begin
                rd_ptr_reg[i] <= '0;
                wr_ptr_reg[i] <= '0;
                count_reg[i]  <= '0;
                total_reg[i]  <= '0;
            end
            streak_reg     <= '0;
            upr_reg        <= tcpqs_pkg::UPR_RESET;
            res_status_reg <= tcpqs_pkg::STATUS_ENQUEUED;
            res_class_reg  <= tcpqs_pkg::CLASS_EMERGENCY;
            res_served_reg <= 1'b0;
            out_item_reg   <= '0;
        end
        else
        begin
            rd_ptr_reg     <= rd_ptr_next;
            wr_ptr_reg     <= wr_ptr_next;
            count_reg      <= count_next;
            total_reg      <= total_next;
            streak_reg     <= streak_next;
            res_status_reg <= res_status_next;
            res_class_reg  <= res_class_next;
            res_served_reg <= res_served_next;
            if (cfg_wr_en)
            begin
                upr_reg <= cfg_wr_data;
            end
            if (cmd.load)
            begin
                out_item_reg.status           <= res_status_reg;
                out_item_reg.served_class     <= res_class_reg;
                out_item_reg.served_id        <= res_served_reg ? rd_data_reg : '0;
                out_item_reg.served_emergency <= total_reg[tcpqs_pkg::CLASS_EMERGENCY];
                out_item_reg.served_urgent    <= total_reg[tcpqs_pkg::CLASS_URGENT];
                out_item_reg.served_regular   <= total_reg[tcpqs_pkg::CLASS_REGULAR];
            end
        end
    end

endmodule

// ===== src/three_class_priority_queue_scheduler.sv =====
// Each item passes through an execute state, which updates the queues and reads or writes
// the client store, and a done state, which loads the result register once the output is
// free while the next item is taken in. No new item is taken in before the done state
// of the last one, so the block handles one item at a time.
// Reset clears all queues, counters and the urgent streak; the register returns to 3.
// Depends on tcpqs_pkg, tcpqs_ctrl and tcpqs_dp.
`timescale 1ns / 1ps

module three_class_priority_queue_scheduler #(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  tcpqs_pkg::in_item_t           in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output tcpqs_pkg::out_item_t          out_item,
    input  logic                          cfg_wr_en,
    input  logic [tcpqs_pkg::UPR_W-1:0]   cfg_wr_data
);

    tcpqs_pkg::cmd_t cmd;

    tcpqs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    tcpqs_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_item     (in_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_item    (out_item)
    );

endmodule

// ===== src/tcpqs_checker.sv =====
// Port-level checker for the scheduler, attached to the top level by bind.
// Depends on tcpqs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcpqs_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input tcpqs_pkg::out_item_t          out_item
);

    logic                         unserved;
    logic                         id_clear;
    logic [tcpqs_pkg::TOTAL_W-1:0] tot_e;
    logic [tcpqs_pkg::TOTAL_W-1:0] tot_r;

    assign unserved = out_valid && (out_item.status != tcpqs_pkg::STATUS_SERVED);
    assign id_clear = (out_item.served_id == '0)
                   && (out_item.served_class == tcpqs_pkg::CLASS_EMERGENCY);
    assign tot_e    = out_item.served_emergency;
    assign tot_r    = out_item.served_regular;

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_item))
    `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)
    `ASSERT_SAME(a_no_serve_no_id, clk, rst_n, unserved, id_clear)
    `ASSERT_SAME(a_emergency_rise, clk, rst_n, 1'b1, tot_e >= $past(tot_e))
    `ASSERT_SAME(a_regular_rise, clk, rst_n, 1'b1, tot_r >= $past(tot_r))

endmodule

bind three_class_priority_queue_scheduler tcpqs_checker u_checker (.*);

// ===== verif/three_class_priority_queue_scheduler_tb.sv =====
// Self-checking testbench for the three-class priority queue scheduler.
// A class mirrors the queues, the urgent streak and the served totals and checks every result.
// Depends on tcpqs_pkg and three_class_priority_queue_scheduler.
`timescale 1ns / 1ps

module three_class_priority_queue_scheduler_tb;

    localparam int QUEUE_DEPTH = 16;
    localparam logic [tcpqs_pkg::ID_W-1:0] ID_MAX = 37'd99999999999;

    class scheduler_book;
        logic [tcpqs_pkg::ID_W-1:0]    client_store [tcpqs_pkg::NUM_CLASSES][QUEUE_DEPTH];
        int unsigned                   head [tcpqs_pkg::NUM_CLASSES];
        int unsigned                   tail [tcpqs_pkg::NUM_CLASSES];
        int unsigned                   waiting [tcpqs_pkg::NUM_CLASSES];
        logic [tcpqs_pkg::TOTAL_W-1:0] served_total [tcpqs_pkg::NUM_CLASSES];
        logic [tcpqs_pkg::UPR_W-1:0]   streak;
        logic [tcpqs_pkg::UPR_W-1:0]   ratio;
        tcpqs_pkg::out_item_t          expected_responses [$];
        int                            mismatches;
        int                            requests;
        int                            responses;

        function new();
            for (int c = 0; c < tcpqs_pkg::NUM_CLASSES; c++)
            begin
                head[c] = 0;
                tail[c] = 0;
                waiting[c] = 0;
                served_total[c] = '0;
            end
            streak = '0;
            ratio = tcpqs_pkg::UPR_RESET;
            mismatches = 0;
            requests = 0;
            responses = 0;
        endfunction

        function tcpqs_pkg::out_item_t schedule_request(tcpqs_pkg::in_item_t req);
            tcpqs_pkg::out_item_t res;
            logic [1:0]           pick;
            int unsigned          c;
            res = '0;
            if (req.req_type == tcpqs_pkg::REQ_ENQUEUE)
            begin
                c = req.client_class;
                if (req.client_class == tcpqs_pkg::CLASS_INVALID)
                    res.status = tcpqs_pkg::STATUS_INVALID;
                else if (waiting[c] >= QUEUE_DEPTH)
                    res.status = tcpqs_pkg::STATUS_FULL;
                else
                begin
                    client_store[c][tail[c]] = req.client_id;
                    tail[c] = (tail[c] + 1) % QUEUE_DEPTH;
                    waiting[c]++;
                    res.status = tcpqs_pkg::STATUS_ENQUEUED;
                end
            end
            else if (waiting[tcpqs_pkg::CLASS_EMERGENCY] == 0 &&
                     waiting[tcpqs_pkg::CLASS_URGENT] == 0 &&
                     waiting[tcpqs_pkg::CLASS_REGULAR] == 0)
                res.status = tcpqs_pkg::STATUS_EMPTY;
            else
            begin
                res.status = tcpqs_pkg::STATUS_SERVED;
                if (waiting[tcpqs_pkg::CLASS_EMERGENCY] != 0)
                    pick = tcpqs_pkg::CLASS_EMERGENCY;
                else if (waiting[tcpqs_pkg::CLASS_URGENT] != 0)
                begin
                    if (streak < ratio)
                    begin
                        pick = tcpqs_pkg::CLASS_URGENT;
                        streak = streak + 1'b1;
                    end
                    else if (waiting[tcpqs_pkg::CLASS_REGULAR] != 0)
                    begin
                        pick = tcpqs_pkg::CLASS_REGULAR;
                        streak = '0;
                    end
                    else
                        pick = tcpqs_pkg::CLASS_URGENT;
                end
                else
                begin
                    pick = tcpqs_pkg::CLASS_REGULAR;
                    streak = '0;
                end
                c = pick;
                res.served_class = pick;
                res.served_id = client_store[c][head[c]];
                head[c] = (head[c] + 1) % QUEUE_DEPTH;
                waiting[c]--;
                if (served_total[c] != tcpqs_pkg::COUNT_MAX)
                    served_total[c] = served_total[c] + 1'b1;
            end
            res.served_emergency = served_total[tcpqs_pkg::CLASS_EMERGENCY];
            res.served_urgent = served_total[tcpqs_pkg::CLASS_URGENT];
            res.served_regular = served_total[tcpqs_pkg::CLASS_REGULAR];
            return res;
        endfunction

        function void note_request(tcpqs_pkg::in_item_t req);
            expected_responses.push_back(schedule_request(req));
            requests++;
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
            end
        endfunction

        function void check_response(tcpqs_pkg::out_item_t got);
            tcpqs_pkg::out_item_t want;
            responses++;
            if (expected_responses.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual status %0d",
                         $time, got.status);
                return;
            end
            want = expected_responses.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("served_class", want.served_class, got.served_class);
            compare_field("served_id", want.served_id, got.served_id);
            compare_field("served_emergency", want.served_emergency, got.served_emergency);
            compare_field("served_urgent", want.served_urgent, got.served_urgent);
            compare_field("served_regular", want.served_regular, got.served_regular);
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    tcpqs_pkg::in_item_t           in_item;
    logic                          out_valid;
    logic                          out_ready;
    tcpqs_pkg::out_item_t          out_item;
    logic                          cfg_wr_en;
    logic [tcpqs_pkg::UPR_W-1:0]   cfg_wr_data;

    scheduler_book book;
    int send_idle_pct;
    int recv_idle_pct;
    int stall_left;

    three_class_priority_queue_scheduler #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            book.note_request(in_item);
        if (rst_n && out_valid && out_ready)
            book.check_response(out_item);
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        #(5_000_000);
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [tcpqs_pkg::ID_W-1:0] random_id();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(15))
            0: return '0;
            1: return ID_MAX;
            default: return tcpqs_pkg::ID_W'(raw % 64'd100000000000);
        endcase
    endfunction

    function automatic tcpqs_pkg::in_item_t make_request(logic [0:0] req, logic [1:0] cls,
                                                         logic [tcpqs_pkg::ID_W-1:0] id);
        tcpqs_pkg::in_item_t item;
        item.req_type = req;
        item.client_class = cls;
        item.client_id = id;
        return item;
    endfunction

    function automatic tcpqs_pkg::in_item_t random_request(int enq_pct, logic [1:0] hot);
        logic [0:0] req;
        logic [1:0] cls;
        req = ($urandom_range(99) < enq_pct) ? tcpqs_pkg::REQ_ENQUEUE : tcpqs_pkg::REQ_SERVE;
        if ($urandom_range(99) < 60)
            cls = hot;
        else
            cls = 2'($urandom_range(3));
        return make_request(req, cls, random_id());
    endfunction

    task automatic offer_item(tcpqs_pkg::in_item_t item);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_item <= item;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic quiesce();
        @(negedge clk);
        in_valid <= 1'b0;
        while (book.expected_responses.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_ratio(logic [tcpqs_pkg::UPR_W-1:0] value);
        quiesce();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        book.ratio = value;
    endtask

    task automatic run_random(int count, bit with_hold);
        int         enq_pct;
        logic [1:0] hot;
        enq_pct = 55;
        hot = tcpqs_pkg::CLASS_URGENT;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                case ($urandom_range(2))
                    0: enq_pct = 55;
                    1: enq_pct = 85;
                    default: enq_pct = 25;
                endcase
                hot = 2'($urandom_range(2));
            end
            if (with_hold && i == count / 3)
                stall_left = 300;
            offer_item(random_request(enq_pct, hot));
        end
    endtask

    task automatic run_directed();
        offer_item(make_request(tcpqs_pkg::REQ_SERVE, tcpqs_pkg::CLASS_INVALID, ID_MAX));
        offer_item(make_request(tcpqs_pkg::REQ_ENQUEUE, tcpqs_pkg::CLASS_INVALID, ID_MAX));
        offer_item(make_request(tcpqs_pkg::REQ_ENQUEUE, tcpqs_pkg::CLASS_EMERGENCY, '0));
        offer_item(make_request(tcpqs_pkg::REQ_ENQUEUE, tcpqs_pkg::CLASS_REGULAR, ID_MAX));
        repeat (4)
            offer_item(make_request(tcpqs_pkg::REQ_ENQUEUE, tcpqs_pkg::CLASS_URGENT,
                                    random_id()));
        repeat (6)
            offer_item(make_request(tcpqs_pkg::REQ_SERVE, tcpqs_pkg::CLASS_EMERGENCY,
                                    random_id()));
        repeat (3)
            offer_item(make_request(tcpqs_pkg::REQ_ENQUEUE, tcpqs_pkg::CLASS_URGENT,
                                    random_id()));
        repeat (3)
            offer_item(make_request(tcpqs_pkg::REQ_SERVE, tcpqs_pkg::CLASS_URGENT,
                                    random_id()));
        offer_item(make_request(tcpqs_pkg::REQ_ENQUEUE, tcpqs_pkg::CLASS_REGULAR, random_id()));
        offer_item(make_request(tcpqs_pkg::REQ_ENQUEUE, tcpqs_pkg::CLASS_URGENT, random_id()));
        repeat (2)
            offer_item(make_request(tcpqs_pkg::REQ_SERVE, tcpqs_pkg::CLASS_REGULAR,
                                    random_id()));
    endtask

    initial
    begin
        book = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        stall_left = 0;
        send_idle_pct = 15;
        recv_idle_pct = 54;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        write_ratio(4'd15);
        run_random(280, 1'b1);
        write_ratio(4'd1);
        run_random(280, 1'b0);

        send_idle_pct = 54;
        recv_idle_pct = 15;
        write_ratio(4'd0);
        run_random(280, 1'b0);
        write_ratio(4'd8);
        run_random(280, 1'b0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_ratio(4'd5);
        run_random(200, 1'b0);
        write_ratio(4'd2);
        run_random(110, 1'b0);

        quiesce();
        repeat (10) @(posedge clk);
        $display("Checked %0d results for %0d requests over ratio settings 0 to 15,",
                 book.responses, book.requests);
        $display("with full and empty queues, invalid classes and long output stalls.");
        if (book.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
